// ===== rtl/cbq_pkg.sv =====
// Shared types, constants and the control store for the cascaded biquad filter.
// Used by cbq_mul and cascaded_biquad_iir_top; depends on nothing else.
`default_nettype none

package cbq_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 32;
  localparam int COEF_FRAC      = 28;
  localparam int SIG_W          = 48;
  localparam int SIG_FRAC       = 16;
  localparam int PROD_W         = SIG_W + COEF_W - COEF_FRAC;
  localparam int SUM_W          = PROD_W + 2;
  localparam int STAGE_CFG_W    = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int DEF_MAX_STAGES = 64;
  localparam int STEP_W         = 4;

  localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_FIN = STEP_W'(8);

  localparam logic signed [SUM_W-1:0] SUM_SIG_MAX =
    {{(SUM_W-SIG_W+1){1'b0}}, {(SIG_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_SIG_MIN =
    {{(SUM_W-SIG_W+1){1'b1}}, {(SIG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEED0  = 3'd0,
    CFG_FEED1  = 3'd1,
    CFG_FEED2  = 3'd2,
    CFG_BACK1  = 3'd3,
    CFG_BACK2  = 3'd4,
    CFG_STAGES = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef enum logic {
    SRC_X = 1'b0,
    SRC_Y = 1'b1
  } mul_src_t;

  typedef enum logic [2:0] {
    CF_FEED0 = 3'd0,
    CF_FEED1 = 3'd1,
    CF_FEED2 = 3'd2,
    CF_BACK1 = 3'd3,
    CF_BACK2 = 3'd4
  } coef_sel_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_Y_LOAD  = 3'd1,
    OP_S1_LOAD = 3'd2,
    OP_S2_LOAD = 3'd3,
    OP_S1_SUB  = 3'd4,
    OP_WRITE   = 3'd5
  } alu_op_t;

  typedef enum logic [1:0] {
    BR_NEXT         = 2'd0,
    BR_EXIT_IF_DONE = 2'd1,
    BR_LOOP         = 2'd2,
    BR_FINISH       = 2'd3
  } branch_t;

  typedef struct packed {
    logic              mem_rd;
    mul_src_t          mul_src;
    coef_sel_t         coef_sel;
    alu_op_t           alu_op;
    branch_t           branch;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // One section takes steps 0 to 7. A product issued in a step is used once it has passed the multiplier's registers.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t cw;
    cw = '{mem_rd: 1'b0, mul_src: SRC_X, coef_sel: CF_FEED0, alu_op: OP_NONE,
           branch: BR_NEXT, target: STEP_TOP};
    case (step)
      4'd0: begin
        cw.mem_rd = 1'b1;
        cw.branch = BR_EXIT_IF_DONE;
        cw.target = STEP_FIN;
      end
      4'd1: begin
        cw.coef_sel = CF_FEED0;
      end
      4'd2: begin
        cw.coef_sel = CF_FEED1;
      end
      4'd3: begin
        cw.coef_sel = CF_FEED2;
        cw.alu_op   = OP_Y_LOAD;
      end
      4'd4: begin
        cw.mul_src  = SRC_Y;
        cw.coef_sel = CF_BACK1;
        cw.alu_op   = OP_S1_LOAD;
      end
      4'd5: begin
        cw.mul_src  = SRC_Y;
        cw.coef_sel = CF_BACK2;
        cw.alu_op   = OP_S2_LOAD;
      end
      4'd6: begin
        cw.alu_op = OP_S1_SUB;
      end
      4'd7: begin
        cw.alu_op = OP_WRITE;
        cw.branch = BR_LOOP;
        cw.target = STEP_TOP;
      end
      default: begin
        cw.branch = BR_FINISH;
      end
    endcase
    return cw;
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [SUM_W-1:0] v);
    if (v > SUM_SIG_MAX) begin
      return SUM_SIG_MAX[SIG_W-1:0];
    end else if (v < SUM_SIG_MIN) begin
      return SUM_SIG_MIN[SIG_W-1:0];
    end
    return v[SIG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cbq_mul.sv =====
// Two-stage rounding multiplier: 48-bit signal times Q3.28 coefficient, rounded half up.
// Depends on cbq_pkg.
`default_nettype none

module cbq_mul (
  input  wire logic                                clk,
  input  wire logic signed [cbq_pkg::SIG_W-1:0]    operand,
  input  wire logic signed [cbq_pkg::COEF_W-1:0]   coef,
  output logic signed      [cbq_pkg::PROD_W-1:0]   prod
);
  import cbq_pkg::*;

  localparam int HALF      = SIG_W / 2;
  localparam int PART_LO_W = HALF + 1 + COEF_W;
  localparam int PART_HI_W = SIG_W - HALF + COEF_W;
  localparam int FULL_W    = SIG_W + COEF_W;
  localparam logic signed [FULL_W-1:0] ROUND = FULL_W'(64'd1 << (COEF_FRAC - 1));

  logic signed [PART_LO_W-1:0] part_lo;
  logic signed [PART_HI_W-1:0] part_hi;
  logic signed [FULL_W-1:0]    full;

  // The low half is taken as unsigned, so the two partial products sum to the exact product.
  always_ff @(posedge clk) begin
    part_lo <= $signed({1'b0, operand[HALF-1:0]}) * coef;
    part_hi <= $signed(operand[SIG_W-1:HALF]) * coef;
  end

  always_comb begin
    full = (FULL_W'(part_hi) <<< HALF) + FULL_W'(part_lo) + ROUND;
  end

  always_ff @(posedge clk) begin
    prod <= full[FULL_W-1:COEF_FRAC];
  end

endmodule

`default_nettype wire

// ===== rtl/cascaded_biquad_iir_top.sv =====
// Cascaded biquad IIR filter, transposed direct form II, run by a microcoded sequencer.
// Depends on cbq_pkg and cbq_mul.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   sample_in, block_end_in
//   out      output     out_valid/out_stall sample_out, block_end_out
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An input transfer starts the section program; the next input transfers only once the
// sequencer is back in idle. For each of n sections, n being stage_count limited to
// MAX_STAGES, the one shared multiplier issues five products in eight control steps.
// Reset is synchronous; it clears the delay state at once through per-entry valid bits.
// A finished result waits in the output register while a new input may transfer;
// the sequencer holds in its last step only while an earlier result is still stalled.
`default_nettype none

module cascaded_biquad_iir_top #(
  parameter int MAX_STAGES = cbq_pkg::DEF_MAX_STAGES
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [cbq_pkg::SAMPLE_W-1:0]   sample_in,
  input  wire logic                                  block_end_in,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [cbq_pkg::SAMPLE_W-1:0]   sample_out,
  output logic                                       block_end_out,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic        [cbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [cbq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cbq_pkg::*;

  localparam int IDX_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CNT_W   = $clog2(MAX_STAGES + 1);
  localparam int ENTRY_W = 2 * SIG_W;
  localparam int RES_W   = SIG_W - SIG_FRAC + 1;
  localparam logic signed [SIG_W:0] HALF_LSB = (SIG_W + 1)'(64'd1 << (SIG_FRAC - 1));
  localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(64'd1 << (SAMPLE_W - 1));

  logic signed [COEF_W-1:0] coef_feed0, coef_feed1, coef_feed2, coef_back1, coef_back2;
  logic [STAGE_CFG_W-1:0]   stage_count;

  state_t             state;
  logic [STEP_W-1:0]  upc;
  logic [CNT_W-1:0]   remaining;
  logic [CNT_W-1:0]   n_eff;
  logic [IDX_W-1:0]   j;
  logic [MAX_STAGES-1:0] valid;
  logic [ENTRY_W-1:0] mem [MAX_STAGES];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_valid;

  logic signed [SIG_W-1:0]  x, y, d1, d2, mul_operand;
  logic signed [COEF_W-1:0] mul_coef;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  prod_ext, s1, s2, y_sum, s1_load, s2_new;
  logic signed [SIG_W:0]    rnd;
  logic signed [RES_W-1:0]  res;
  logic                     blk;
  logic                     running, finish, out_free;
  ucode_t                   cw;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != ST_IDLE);
  assign running   = (state == ST_RUN);
  assign cw        = ucode_rom(upc);
  assign out_free  = !out_valid || !out_stall;
  assign finish    = running && (cw.branch == BR_FINISH) && out_free;
  assign n_eff     = (32'(stage_count) > MAX_STAGES) ? CNT_W'(MAX_STAGES)
                                                     : CNT_W'(stage_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_feed0  <= '0;
      coef_feed1  <= '0;
      coef_feed2  <= '0;
      coef_back1  <= '0;
      coef_back2  <= '0;
      stage_count <= STAGE_CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FEED0:  coef_feed0  <= cfg_data;
        CFG_FEED1:  coef_feed1  <= cfg_data;
        CFG_FEED2:  coef_feed2  <= cfg_data;
        CFG_BACK1:  coef_back1  <= cfg_data;
        CFG_BACK2:  coef_back2  <= cfg_data;
        CFG_STAGES: stage_count <= cfg_data[STAGE_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mul_operand = (cw.mul_src == SRC_Y) ? y : x;
    unique case (cw.coef_sel)
      CF_FEED0: mul_coef = coef_feed0;
      CF_FEED1: mul_coef = coef_feed1;
      CF_FEED2: mul_coef = coef_feed2;
      CF_BACK1: mul_coef = coef_back1;
      CF_BACK2: mul_coef = coef_back2;
      default:  mul_coef = '0;
    endcase
  end

  cbq_mul u_mul (
    .clk     (clk),
    .operand (mul_operand),
    .coef    (mul_coef),
    .prod    (prod)
  );

  assign d1       = rd_valid ? $signed(rd_data[ENTRY_W-1:SIG_W]) : '0;
  assign d2       = rd_valid ? $signed(rd_data[SIG_W-1:0]) : '0;
  assign prod_ext = SUM_W'(prod);
  assign y_sum    = prod_ext + SUM_W'(d1);
  assign s1_load  = prod_ext + SUM_W'(d2);
  assign s2_new   = s2 - prod_ext;

  // Output rounding: floor((x + one half LSB) / 2^16), then clamp to 16 bits.
  assign rnd = {x[SIG_W-1], x} + HALF_LSB;
  assign res = rnd[SIG_W:SIG_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      upc       <= STEP_TOP;
      remaining <= '0;
      j         <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            remaining <= n_eff;
            j         <= '0;
            upc       <= STEP_TOP;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cw.alu_op == OP_WRITE) begin
            valid[j]  <= 1'b1;
            j         <= j + IDX_W'(1);
            remaining <= remaining - CNT_W'(1);
          end
          unique case (cw.branch)
            BR_NEXT: upc <= upc + STEP_W'(1);
            BR_EXIT_IF_DONE: begin
              upc <= (remaining == '0) ? cw.target : upc + STEP_W'(1);
            end
            BR_LOOP: upc <= cw.target;
            BR_FINISH: begin
              if (out_free) begin
                state <= ST_IDLE;
              end
            end
            default: upc <= STEP_TOP;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      x   <= SIG_W'($signed({sample_in, {SIG_FRAC{1'b0}}}));
      blk <= block_end_in;
    end else if (running) begin
      case (cw.alu_op)
        OP_Y_LOAD:  y  <= sat_sig(y_sum);
        OP_S1_LOAD: s1 <= s1_load;
        OP_S2_LOAD: s2 <= prod_ext;
        OP_S1_SUB:  s1 <= s1 - prod_ext;
        OP_WRITE:   x  <= y;
        default: begin
        end
      endcase
    end
    if (finish) begin
      block_end_out <= blk;
      if (res > OUT_MAX) begin
        sample_out <= OUT_MAX[SAMPLE_W-1:0];
      end else if (res < OUT_MIN) begin
        sample_out <= OUT_MIN[SAMPLE_W-1:0];
      end else begin
        sample_out <= res[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running && cw.mem_rd) begin
      rd_data  <= mem[j];
      rd_valid <= valid[j];
    end
    if (running && cw.alu_op == OP_WRITE) begin
      mem[j] <= {sat_sig(s1), sat_sig(s2_new)};
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_RUN && upc == STEP_TOP && remaining <= CNT_W'(MAX_STAGES))
    else $error("input transfer did not start the section program");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RUN && upc == STEP_FIN))
    else $error("result appeared outside the finish step");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    running && cw.alu_op == OP_WRITE |-> remaining != '0 && 32'(j) < MAX_STAGES)
    else $error("delay write beyond the sections in use");

  a_finish_not_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out))
    else $error("stalled result was overwritten");

endmodule

`default_nettype wire
